// ----- hw/rtl/asrb_pkg.sv -----
// ----------------------------------------------------------------------------
// asrb_pkg
// Shared constants, codes and types of the ADC scan sequencer with its
// circular sample buffer.
// ----------------------------------------------------------------------------
package asrb_pkg;

    // Sizing of the sample ring and of the channel schedule
    localparam int BUF_DEPTH = 64;
    localparam int SCHED_MAX = 8;
    localparam int PTR_W     = $clog2(BUF_DEPTH);

    // Field widths
    localparam int CMD_W      = 3;
    localparam int SAMPLE_W   = 8;
    localparam int CHAN_W     = 4;
    localparam int SLOT_W     = 3;
    localparam int STORED_W   = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SCHED_W    = 32;

    localparam logic [SLOT_W-1:0] SCHED_CAP_MASK = SLOT_W'(SCHED_MAX - 1);
    localparam logic [SLOT_W-1:0] SCHED_BACK     = SLOT_W'(SCHED_MAX - 1);
    localparam logic [PTR_W-1:0]  BUF_CAP_MASK   = PTR_W'(BUF_DEPTH - 1);

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TRIGGER   = 3'd0,
        CMD_CONV_DONE = 3'd1,
        CMD_RESET_PTR = 3'd2,
        CMD_POP       = 3'd3,
        CMD_DISABLE   = 3'd4
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MANUAL_MODE   = 2'd0,
        REG_SCHED_LEN_LOG = 2'd1,
        REG_BUF_LEN_LOG   = 2'd2,
        REG_SCHED_CHANS   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic               manual_mode;
        logic [1:0]         schedule_len_log2;
        logic [2:0]         buffer_len_log2;
        logic [SCHED_W-1:0] schedule_channels;
    } t_cfg;

    // Result of one item, bar the sample read from the ring
    typedef struct packed {
        logic [CHAN_W-1:0]   sample_channel;
        logic [CHAN_W-1:0]   next_channel;
        logic                busy_res;
        logic                auto_trigger;
        logic                converter_on;
        logic [STORED_W-1:0] stored_index;
        logic                overwrote;
        logic                read_valid;
    } t_result;

    // Ring access for one item
    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [PTR_W-1:0]    rd_addr;
    } t_ram_req;

    // Channel number held in a schedule slot
    function automatic logic [CHAN_W-1:0] slot_channel(
        input logic [SCHED_W-1:0] chans,
        input logic [SLOT_W-1:0]  slot,
        input logic [SLOT_W-1:0]  smask
    );
        logic [SLOT_W-1:0] k;
        k = slot & smask;
        return chans[{k, 2'b00} +: CHAN_W];
    endfunction

endpackage

// ----- hw/rtl/asrb_ifs.sv -----
// ----------------------------------------------------------------------------
// asrb channel interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface asrb_in_if;
    logic                              valid;
    logic                              ready;
    logic [asrb_pkg::CMD_W-1:0]        command;
    logic [asrb_pkg::SAMPLE_W-1:0]     sample;

    modport source (output valid, command, sample, input ready);
    modport sink   (input valid, command, sample, output ready);
endinterface

interface asrb_out_if;
    logic                              valid;
    logic                              ready;
    logic [asrb_pkg::CHAN_W-1:0]       sample_channel;
    logic [asrb_pkg::CHAN_W-1:0]       next_channel;
    logic                              busy_res;
    logic                              auto_trigger;
    logic                              converter_on;
    logic [asrb_pkg::STORED_W-1:0]     stored_index;
    logic                              overwrote;
    logic [asrb_pkg::SAMPLE_W-1:0]     read_data;
    logic                              read_valid;

    modport source (output valid, sample_channel, next_channel, busy_res, auto_trigger,
                    converter_on, stored_index, overwrote, read_data, read_valid,
                    input ready);
    modport sink   (input valid, sample_channel, next_channel, busy_res, auto_trigger,
                    converter_on, stored_index, overwrote, read_data, read_valid,
                    output ready);
endinterface

interface asrb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [asrb_pkg::CFG_ADDR_W-1:0]   addr;
    logic [asrb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/asrb_ram.sv -----
// ----------------------------------------------------------------------------
// asrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module asrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/asrb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// asrb_cfg_regs
// Configuration registers: mode, schedule length, ring length, schedule.
// ----------------------------------------------------------------------------
module asrb_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [asrb_pkg::CFG_ADDR_W-1:0]   i_addr,
    input  logic [asrb_pkg::CFG_DATA_W-1:0]   i_data,
    output asrb_pkg::t_cfg                    o_cfg
);
    import asrb_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manual_mode       <= 1'b0;
            r_cfg.schedule_len_log2 <= 2'd0;
            r_cfg.buffer_len_log2   <= 3'd6;
            r_cfg.schedule_channels <= '0;
        end else if (i_wr_en) begin
            case (t_cfg_reg'(i_addr))
                REG_MANUAL_MODE:   r_cfg.manual_mode       <= i_data[0];
                REG_SCHED_LEN_LOG: r_cfg.schedule_len_log2 <= i_data[1:0];
                REG_BUF_LEN_LOG:   r_cfg.buffer_len_log2   <= i_data[2:0];
                REG_SCHED_CHANS:   r_cfg.schedule_channels <= i_data[SCHED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/asrb_core.sv -----
// ----------------------------------------------------------------------------
// asrb_core
// Sequencer state (ring pointers and flags) and the next-state and result
// logic for one registered item.
// ----------------------------------------------------------------------------
module asrb_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  asrb_pkg::t_cfg                  i_cfg,
    input  logic                            i_adv,
    input  logic [asrb_pkg::CMD_W-1:0]      i_command,
    input  logic [asrb_pkg::SAMPLE_W-1:0]   i_sample,
    output asrb_pkg::t_result               o_res,
    output asrb_pkg::t_ram_req              o_ram
);
    import asrb_pkg::*;

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_busy, n_busy;
    logic             r_auto, n_auto;
    logic             r_on, n_on;

    logic [2:0]        buf_lg;
    logic [PTR_W-1:0]  bmask;
    logic [SLOT_W-1:0] smask;
    logic [PTR_W-1:0]  slot_t;
    logic [SLOT_W-1:0] slot_idx;
    logic [PTR_W-1:0]  pop_ptr;
    t_result           res;
    t_ram_req          ram;

    // Ring and schedule masks from the length registers
    always_comb begin
        buf_lg = (i_cfg.buffer_len_log2 == 3'd0) ? 3'd1 : i_cfg.buffer_len_log2;
        for (int j = 0; j < PTR_W; j++) begin
            bmask[j] = (3'(j) < buf_lg);
        end
        bmask = bmask & BUF_CAP_MASK;
        for (int j = 0; j < SLOT_W; j++) begin
            smask[j] = (2'(j) < i_cfg.schedule_len_log2);
        end
        smask = smask & SCHED_CAP_MASK;
    end

    assign slot_t   = (r_wr_ptr + PTR_W'(1)) & bmask;
    assign slot_idx = SLOT_W'(slot_t) & smask;
    assign pop_ptr  = (r_rd_ptr + PTR_W'(1)) & bmask;

    // Decode the command and work out state and result
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_busy   = r_busy;
        n_auto   = r_auto;
        n_on     = r_on;
        res      = '0;
        ram      = '0;
        ram.wr_addr = slot_t;
        ram.wr_data = i_sample;
        ram.rd_addr = pop_ptr;
        case (t_cmd'(i_command))
            CMD_TRIGGER: begin
                n_busy = 1'b1;
                n_auto = 1'b1;
                n_on   = 1'b1;
                res.sample_channel = slot_channel(i_cfg.schedule_channels,
                                                  SLOT_W'(r_wr_ptr), smask);
                res.next_channel   = slot_channel(i_cfg.schedule_channels,
                                                  SLOT_W'(r_wr_ptr) + SLOT_W'(1), smask);
            end
            CMD_CONV_DONE: begin
                if (r_on) begin
                    // drop the oldest entry when the ring is full
                    if (slot_t == r_rd_ptr) begin
                        n_rd_ptr      = (slot_t + PTR_W'(1)) & bmask;
                        res.overwrote = 1'b1;
                    end
                    ram.wr_en = 1'b1;
                    n_wr_ptr  = slot_t;
                    if (i_cfg.manual_mode) begin
                        n_busy = 1'b1;
                        if (slot_idx == smask) begin
                            n_auto = 1'b0;
                        end else if (slot_idx == '0) begin
                            n_auto = 1'b1;
                            n_busy = 1'b0;
                        end
                    end
                    res.stored_index   = STORED_W'(slot_t);
                    res.sample_channel = slot_channel(i_cfg.schedule_channels,
                                                      SLOT_W'(slot_t) + SCHED_BACK, smask);
                    res.next_channel   = slot_channel(i_cfg.schedule_channels,
                                                      SLOT_W'(slot_t) + SLOT_W'(1), smask);
                end
            end
            CMD_RESET_PTR: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
            end
            CMD_POP: begin
                if (r_wr_ptr != r_rd_ptr) begin
                    n_rd_ptr       = pop_ptr;
                    res.read_valid = 1'b1;
                end
            end
            CMD_DISABLE: begin
                n_busy = 1'b0;
                n_auto = 1'b0;
                n_on   = 1'b0;
            end
            default: begin
            end
        endcase
        res.busy_res     = n_busy;
        res.auto_trigger = n_auto;
        res.converter_on = n_on;
        ram.wr_en = ram.wr_en & i_adv;
        ram.rd_en = i_adv;
    end

    // Advance state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_busy   <= 1'b0;
            r_auto   <= 1'b1;
            r_on     <= 1'b0;
        end else if (i_adv) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_busy   <= n_busy;
            r_auto   <= n_auto;
            r_on     <= n_on;
        end
    end

    assign o_res = res;
    assign o_ram = ram;

endmodule

// ----- hw/rtl/adc_scan_sequencer_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// adc_scan_sequencer_ring_buffer
// ADC scan sequencer with a power-of-two circular sample buffer.
// ----------------------------------------------------------------------------
// Channels: i_in carries command items (trigger, conversion done with its
// sample, reset pointers, pop oldest, disable); o_out returns exactly one
// result item per command item, in order. i_cfg writes the four registers
// (manual mode, schedule length, ring length, packed schedule) and is
// always ready; write it only while no item is in flight.
// An accepted item waits in the input register, which feeds the decode and
// ring access; these load the result register and the RAM's registered read
// port together when the item advances.
// Throughput is one item per cycle while o_out is not stalled; the sample RAM takes at most one write
// and one read per item.
// Reset clears the pointers, busy and converter-on, sets auto trigger and
// loads the register defaults; the sample RAM is not cleared.
// When the receiver stalls the result is held, the input register still
// takes one more item, and i_in.ready then falls until o_out drains.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_ring_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asrb_in_if.sink     i_in,
    asrb_out_if.source  o_out,
    asrb_cfg_if.sink    i_cfg
);
    import asrb_pkg::*;

    logic                r_in_valid;
    logic [CMD_W-1:0]    r_command;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    t_result             r_res;

    logic                advance;
    logic                accept;
    t_cfg                cfg;
    t_result             res;
    t_ram_req            ram;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign accept  = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    asrb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg.valid),
        .i_addr  (i_cfg.addr),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // Sequencer state and item decode
    asrb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_adv     (advance),
        .i_command (r_command),
        .i_sample  (r_sample),
        .o_res     (res),
        .o_ram     (ram)
    );

    // Sample ring
    asrb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram.wr_en),
        .i_waddr (ram.wr_addr),
        .i_wdata (ram.wr_data),
        .i_re    (ram.rd_en),
        .i_raddr (ram.rd_addr),
        .o_rdata (ram_rdata)
    );

    // Input and result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the item, then its result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command <= i_in.command;
            r_sample  <= i_in.sample;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sample_channel = r_res.sample_channel;
    assign o_out.next_channel   = r_res.next_channel;
    assign o_out.busy_res       = r_res.busy_res;
    assign o_out.auto_trigger   = r_res.auto_trigger;
    assign o_out.converter_on   = r_res.converter_on;
    assign o_out.stored_index   = r_res.stored_index;
    assign o_out.overwrote      = r_res.overwrote;
    assign o_out.read_valid     = r_res.read_valid;
    assign o_out.read_data      = r_res.read_valid ? ram_rdata : '0;

    // A pop result never also reports a stored sample
    a_pop_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.read_valid |-> r_res.stored_index == '0 && !r_res.overwrote)
        else $error("pop result also reports a stored sample");

    // Overwrite only happens with the converter enabled
    a_ovw_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.overwrote |-> r_res.converter_on)
        else $error("overwrite reported while converter off");

    // Busy never stands without the converter
    a_busy_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.converter_on |-> !r_res.busy_res)
        else $error("busy reported while converter off");

    // The input register can only be refilled once its item has moved on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input register overrun");

endmodule
